/* rtl/core/tpt_pkg.sv */
// shared types and constants for the tlb and page table translation block
// no dependencies; imported by the top level and its port checker

package tpt_pkg;

    localparam int ADDR_W = 16;
    localparam int CNT_W  = 32;

    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int PAGE_COUNT_DEF   = 256;
    localparam int OFFSET_WIDTH_DEF = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_LOOKUP
    } tpt_state_t;

endpackage

/* rtl/core/tlb_page_table_translate.sv */
// translates logical addresses through a fully associative tlb and a page table memory
// depends on tpt_pkg

// Each transaction runs these steps: the page number is reduced modulo PAGE_COUNT by a
// reciprocal multiply registered at acceptance and corrected in ST_CALC, which also
// addresses the synchronous page table read; ST_LOOKUP then searches the tlb, allocates a
// frame on a fault, writes the page table back and updates the tlb and counters. busy is
// low in the cycle the result is shown, so a new transaction may start then, and not
// while one is still in flight. done is high for exactly one cycle, and the result is
// held on the output ports until the next lookup; the receiver cannot stall it and must
// take it then. The counts are also held between transactions. After reset the block
// clears the page table present bits, one entry a cycle, with busy high until all are done.
module tlb_page_table_translate #(
    parameter int TLB_ENTRIES  = tpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT   = tpt_pkg::PAGE_COUNT_DEF,
    parameter int OFFSET_WIDTH = tpt_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tpt_pkg::ADDR_W-1:0] logical_address,
    output logic                       busy,
    output logic                       done,
    output logic [tpt_pkg::ADDR_W-1:0] physical_address,
    output logic                       tlb_hit,
    output logic                       page_fault,
    output logic [tpt_pkg::CNT_W-1:0]  hit_count,
    output logic [tpt_pkg::CNT_W-1:0]  fault_count,
    output logic [tpt_pkg::CNT_W-1:0]  address_count
);
    import tpt_pkg::*;

    localparam int VPN_W = ADDR_W - OFFSET_WIDTH;
    localparam int VW    = (VPN_W > 0) ? VPN_W : 1;
    localparam int PW    = $clog2(PAGE_COUNT);
    localparam int TW    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int SH    = VW + PW;
    localparam int PRW   = VW + SH;
    localparam int RW    = VW + PW + 1;
    localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / PAGE_COUNT);
    localparam logic [PW-1:0] PAGE_LAST = PW'(PAGE_COUNT - 1);
    localparam logic [TW-1:0] SLOT_LAST = TW'(TLB_ENTRIES - 1);

    tpt_state_t state_reg, state_next;

    logic [PW-1:0]           clr_cnt_reg;
    logic [PRW-1:0]          prod_reg;
    logic [VW-1:0]           vpn_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [PW-1:0]           page_reg;

    // page table: present bit above the frame number
    logic [PW:0]             pt_mem [PAGE_COUNT];
    logic [PW:0]             pt_rdata_reg;
    logic [PW-1:0]           mem_addr;
    logic                    mem_we;
    logic [PW:0]             mem_wdata;

    logic [PW-1:0]           tlb_page_reg  [TLB_ENTRIES];
    logic [PW-1:0]           tlb_frame_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]  tlb_valid_reg;
    logic [TW-1:0]           fill_slot_reg;
    logic [PW-1:0]           free_frame_reg;

    logic [CNT_W-1:0]        hits_reg;
    logic [CNT_W-1:0]        faults_reg;
    logic [CNT_W-1:0]        xlates_reg;

    logic                    done_reg;
    logic [ADDR_W-1:0]       phys_reg;
    logic                    hit_reg;
    logic                    fault_reg;

    logic                    accept;
    logic [VW-1:0]           vpn_in;
    logic [VW-1:0]           q_est;
    logic [RW-1:0]           qp;
    logic [RW-1:0]           diff;
    logic [PW-1:0]           page_calc;
    logic                    hit;
    logic [PW-1:0]           hit_frame;
    logic                    fault;
    logic [PW-1:0]           frame;

    assign accept = start && (state_reg == ST_IDLE);
    assign vpn_in = VW'(logical_address >> OFFSET_WIDTH);

    // page modulo PAGE_COUNT: quotient estimate is exact or one low
    assign q_est = prod_reg[PRW-1:SH];
    assign qp    = RW'(q_est) * RW'(PAGE_COUNT);
    assign diff  = RW'(vpn_reg) - qp;
    assign page_calc = (diff >= RW'(PAGE_COUNT)) ? PW'(diff - RW'(PAGE_COUNT)) : PW'(diff);

    // lowest valid matching entry wins
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_reg))
            begin
                hit       = 1'b1;
                hit_frame = tlb_frame_reg[i];
            end
        end
    end

    always_comb
    begin
        fault = !hit && !pt_rdata_reg[PW];
        if (hit)
            frame = hit_frame;
        else if (pt_rdata_reg[PW])
            frame = pt_rdata_reg[PW-1:0];
        else
            frame = free_frame_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        mem_addr   = page_reg;
        mem_we     = 1'b0;
        mem_wdata  = {1'b1, free_frame_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_addr  = clr_cnt_reg;
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (clr_cnt_reg == PAGE_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                mem_addr   = page_calc;
                state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                mem_we     = fault;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (state_reg == ST_CLEAR)
            clr_cnt_reg <= clr_cnt_reg + PW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            pt_mem[mem_addr] <= mem_wdata;
        pt_rdata_reg <= pt_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg   <= PRW'(vpn_in) * PRW'(RECIP);
            vpn_reg    <= vpn_in;
            offset_reg <= logical_address[OFFSET_WIDTH-1:0];
        end
        if (state_reg == ST_CALC)
            page_reg <= page_calc;
        if (state_reg == ST_LOOKUP)
        begin
            phys_reg  <= ADDR_W'((32'(frame) << OFFSET_WIDTH) + 32'(offset_reg));
            hit_reg   <= hit;
            fault_reg <= fault;
            if (!hit)
            begin
                tlb_page_reg[fill_slot_reg]  <= page_reg;
                tlb_frame_reg[fill_slot_reg] <= frame;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlb_valid_reg  <= '0;
            fill_slot_reg  <= '0;
            free_frame_reg <= '0;
            hits_reg       <= '0;
            faults_reg     <= '0;
            xlates_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_LOOKUP);
            if (state_reg == ST_LOOKUP)
            begin
                xlates_reg <= xlates_reg + CNT_W'(1);
                if (hit)
                    hits_reg <= hits_reg + CNT_W'(1);
                else
                begin
                    tlb_valid_reg[fill_slot_reg] <= 1'b1;
                    fill_slot_reg <= (fill_slot_reg == SLOT_LAST) ? '0
                                                                  : fill_slot_reg + TW'(1);
                end
                if (fault)
                begin
                    faults_reg     <= faults_reg + CNT_W'(1);
                    free_frame_reg <= (free_frame_reg == PAGE_LAST) ? '0
                                                                    : free_frame_reg + PW'(1);
                end
            end
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign physical_address = phys_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;
    assign hit_count        = hits_reg;
    assign fault_count      = faults_reg;
    assign address_count    = xlates_reg;

endmodule

/* rtl/core/tpt_checker.sv */
// port-level checks for tlb_page_table_translate, attached with a bind
// depends on tpt_pkg

module tpt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       done,
    input logic                       tlb_hit,
    input logic                       page_fault,
    input logic [tpt_pkg::CNT_W-1:0]  address_count
);
    import tpt_pkg::*;

    // every accepted transaction raises done once it has passed ST_CALC and ST_LOOKUP
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result strobe missing after accepted transaction");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a tlb hit never allocates a frame
    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && tlb_hit) |-> !page_fault)
        else $error("tlb hit reported together with page fault");

    // each result counts exactly one translation
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (address_count == $past(address_count) + CNT_W'(1)))
        else $error("address count did not advance by one");

endmodule

bind tlb_page_table_translate tpt_checker u_tpt_checker (.*);

/* dv/tpt_checker.sv */
`timescale 1ns / 1ps
// scoreboard for the tlb and page table translation block: predicts every translation
// and compares each done strobe against it; depends on tpt_pkg

module tpt_scoreboard
    import tpt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [ADDR_W-1:0] logical_address,
    input  logic              done,
    input  logic [ADDR_W-1:0] physical_address,
    input  logic              tlb_hit,
    input  logic              page_fault,
    input  logic [CNT_W-1:0]  hit_count,
    input  logic [CNT_W-1:0]  fault_count,
    input  logic [CNT_W-1:0]  address_count,
    output int                errors,
    output int                pending
);

    localparam int TLB_N  = TLB_ENTRIES_DEF;
    localparam int PAGES  = PAGE_COUNT_DEF;
    localparam int OFS_W  = OFFSET_WIDTH_DEF;
    localparam int PAGE_W = $clog2(PAGES);

    typedef struct packed {
        logic [ADDR_W-1:0] physical_address;
        logic              tlb_hit;
        logic              page_fault;
        logic [CNT_W-1:0]  hit_count;
        logic [CNT_W-1:0]  fault_count;
        logic [CNT_W-1:0]  address_count;
    } translation_t;

    // shadow copy of the translation state
    logic [PAGE_W-1:0] tlb_page_m    [TLB_N];
    logic [PAGE_W-1:0] tlb_frame_m   [TLB_N];
    logic              tlb_valid_m   [TLB_N];
    logic [PAGE_W-1:0] page_frame_m  [PAGES];
    logic              page_mapped_m [PAGES];
    int                fill_slot;
    logic [PAGE_W-1:0] free_frame;
    logic [CNT_W-1:0]  hits_seen;
    logic [CNT_W-1:0]  faults_seen;
    logic [CNT_W-1:0]  lookups_seen;

    translation_t expected_translations [$];

    function automatic translation_t translate_address(input logic [ADDR_W-1:0] addr);
        translation_t      r;
        logic [PAGE_W-1:0] page;
        logic [PAGE_W-1:0] frame;
        logic [31:0]       offset;
        logic              hit;
        logic              fault;
        hit    = 1'b0;
        fault  = 1'b0;
        frame  = '0;
        offset = 32'(addr) & ((32'd1 << OFS_W) - 32'd1);
        page   = PAGE_W'((32'(addr) >> OFS_W) % PAGES);
        lookups_seen = lookups_seen + CNT_W'(1);
        for (int i = 0; i < TLB_N; i++) begin
            if (!hit && tlb_valid_m[i] && tlb_page_m[i] == page) begin
                frame = tlb_frame_m[i];
                hit   = 1'b1;
            end
        end
        if (hit) begin
            hits_seen = hits_seen + CNT_W'(1);
        end
        else begin
            if (page_mapped_m[page]) begin
                frame = page_frame_m[page];
            end
            else begin
                // demand paging: frames handed out in order, wrapping
                frame               = free_frame;
                free_frame          = PAGE_W'((32'(free_frame) + 1) % PAGES);
                page_frame_m[page]  = frame;
                page_mapped_m[page] = 1'b1;
                fault               = 1'b1;
                faults_seen         = faults_seen + CNT_W'(1);
            end
            tlb_page_m[fill_slot]  = page;
            tlb_frame_m[fill_slot] = frame;
            tlb_valid_m[fill_slot] = 1'b1;
            fill_slot              = (fill_slot + 1) % TLB_N;
        end
        r.physical_address = ADDR_W'((32'(frame) << OFS_W) + offset);
        r.tlb_hit          = hit;
        r.page_fault       = fault;
        r.hit_count        = hits_seen;
        r.fault_count      = faults_seen;
        r.address_count    = lookups_seen;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : scoreboard
        translation_t want;
        if (!rst_n) begin
            for (int i = 0; i < TLB_N; i++) begin
                tlb_page_m[i]  = '0;
                tlb_frame_m[i] = '0;
                tlb_valid_m[i] = 1'b0;
            end
            for (int i = 0; i < PAGES; i++) begin
                page_frame_m[i]  = '0;
                page_mapped_m[i] = 1'b0;
            end
            fill_slot    = 0;
            free_frame   = '0;
            hits_seen    = '0;
            faults_seen  = '0;
            lookups_seen = '0;
            expected_translations.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            // compare first: a result never belongs to the transaction accepted at this edge
            if (done) begin
                if (expected_translations.size() == 0) begin
                    $display("%0t: result with no transaction outstanding, expected none actual %h",
                             $time, physical_address);
                    errors++;
                end
                else begin
                    want = expected_translations.pop_front();
                    check_field("physical_address", 32'(want.physical_address),
                                32'(physical_address));
                    check_field("tlb_hit", 32'(want.tlb_hit), 32'(tlb_hit));
                    check_field("page_fault", 32'(want.page_fault), 32'(page_fault));
                    check_field("hit_count", want.hit_count, hit_count);
                    check_field("fault_count", want.fault_count, fault_count);
                    check_field("address_count", want.address_count, address_count);
                end
            end
            if (start && !busy)
                expected_translations.push_back(translate_address(logical_address));
            pending = expected_translations.size();
        end
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// top of the translation testbench: clock, reset, address stimulus and the verdict
// depends on tpt_pkg, tlb_page_table_translate and tpt_scoreboard

module tb_top;
    import tpt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1170;

    logic              clk             = 1'b0;
    logic              rst_n           = 1'b0;
    logic              start           = 1'b0;
    logic [ADDR_W-1:0] logical_address = '0;
    logic              busy;
    logic              done;
    logic [ADDR_W-1:0] physical_address;
    logic              tlb_hit;
    logic              page_fault;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  fault_count;
    logic [CNT_W-1:0]  address_count;

    int mismatches;
    int outstanding;
    int cycle_cnt;
    int burst_left = 0;

    tlb_page_table_translate uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .logical_address  (logical_address),
        .busy             (busy),
        .done             (done),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hit_count        (hit_count),
        .fault_count      (fault_count),
        .address_count    (address_count)
    );

    tpt_scoreboard u_scoreboard (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .logical_address  (logical_address),
        .done             (done),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hit_count        (hit_count),
        .fault_count      (fault_count),
        .address_count    (address_count),
        .errors           (mismatches),
        .pending          (outstanding)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("simulation failed");
        $finish;
    end

    // holds start and the address until the transaction is taken
    task automatic issue_address(input logic [ADDR_W-1:0] addr);
        start           <= 1'b1;
        logical_address <= addr;
        do @(posedge clk); while (busy);
    endtask

    // bursts of back to back transactions separated by random idle gaps
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end
        else begin
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
            gap        = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin : stimulus
        logic [7:0] sweep [PAGE_COUNT_DEF];
        logic [7:0] working [24];
        logic [7:0] swap;
        int         ws_size;
        int         k;
        ws_size = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, hits, fifo eviction, page table hit after eviction
        issue_address(16'h0000);
        issue_address(16'h00ff);
        issue_address(16'hffff);
        issue_address(16'hff00);
        for (int p = 1; p <= 16; p++)
            issue_address({8'(p), (p % 2 == 1) ? 8'h55 : 8'haa});
        issue_address(16'h0080);
        issue_address(16'hff7f);
        issue_address(16'h0f01);
        wait_drained();

        // visit every page once in random order so all frames get handed out
        for (int i = 0; i < PAGE_COUNT_DEF; i++)
            sweep[i] = 8'(i);
        for (int i = PAGE_COUNT_DEF - 1; i > 0; i--) begin
            k        = $urandom_range(0, i);
            swap     = sweep[i];
            sweep[i] = sweep[k];
            sweep[k] = swap;
        end
        for (int i = 0; i < PAGE_COUNT_DEF; i++) begin
            pace_sender();
            issue_address({sweep[i], 8'($urandom)});
        end

        // mostly a small working set for tlb hits and fifo thrash, the rest anywhere
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                ws_size = $urandom_range(2, 24);
                for (int i = 0; i < ws_size; i++)
                    working[i] = 8'($urandom);
            end
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            pace_sender();
            if ($urandom_range(0, 9) < 7)
                issue_address({working[$urandom_range(0, ws_size - 1)], 8'($urandom)});
            else
                issue_address(16'($urandom));
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
